// File: hdl/mbd_pkg.sv
`timescale 1ns / 1ps

package mbd_pkg;

    // access kinds
    localparam logic [1:0] KIND_CPU_READ   = 2'd0;
    localparam logic [1:0] KIND_CPU_WRITE  = 2'd1;
    localparam logic [1:0] KIND_VIDEO_READ = 2'd2;

    // target devices
    localparam logic [3:0] TGT_RAM    = 4'd0;
    localparam logic [3:0] TGT_BASIC  = 4'd1;
    localparam logic [3:0] TGT_KERNAL = 4'd2;
    localparam logic [3:0] TGT_CHAR   = 4'd3;
    localparam logic [3:0] TGT_VIDEO  = 4'd4;
    localparam logic [3:0] TGT_SOUND  = 4'd5;
    localparam logic [3:0] TGT_COLOUR = 4'd6;
    localparam logic [3:0] TGT_CIA1   = 4'd7;
    localparam logic [3:0] TGT_CIA2   = 4'd8;
    localparam logic [3:0] TGT_IO1    = 4'd9;
    localparam logic [3:0] TGT_IO2    = 4'd10;
    localparam logic [3:0] TGT_PORT   = 4'd11;

    // map cell codes
    localparam logic [2:0] MAP_RAM    = 3'd0;
    localparam logic [2:0] MAP_BASIC  = 3'd1;
    localparam logic [2:0] MAP_IO     = 3'd2;
    localparam logic [2:0] MAP_KERNAL = 3'd3;
    localparam logic [2:0] MAP_CHAR   = 3'd4;

    // fixed addresses and masks
    localparam logic [15:0] ADDR_PORT   = 16'h0001;
    localparam logic [15:0] BASIC_BASE  = 16'hA000;
    localparam logic [15:0] CHAR_BASE   = 16'hD000;
    localparam logic [15:0] KERNAL_BASE = 16'hE000;
    localparam logic [7:0]  PORT_RESET  = 8'h37;
    localparam logic [7:0]  PORT_FORCE  = 8'h10;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
        logic [1:0]  video_bank_bits;
    } t_item;

    typedef struct packed {
        logic [3:0]  target;
        logic [15:0] offset;
        logic [7:0]  port_value;
    } t_result;

    // Map row contents: column 0 A000-BFFF, 1 D000-DFFF, 2 E000-FFFF
    function automatic logic [2:0] map_cell(input logic [2:0] row, input logic [1:0] col);
        logic [2:0] entry;
        entry = MAP_RAM;
        case (col)
            2'd0: entry = (row == 3'd3 || row == 3'd7) ? MAP_BASIC : MAP_RAM;
            2'd1: begin
                case (row)
                    3'd1, 3'd2, 3'd3: entry = MAP_CHAR;
                    3'd5, 3'd6, 3'd7: entry = MAP_IO;
                    default:          entry = MAP_RAM;
                endcase
            end
            2'd2: entry = (row == 3'd2 || row == 3'd3 || row == 3'd6 || row == 3'd7)
                          ? MAP_KERNAL : MAP_RAM;
            default: entry = MAP_RAM;
        endcase
        return entry;
    endfunction

endpackage

// File: hdl/mbd_decode.sv
`timescale 1ns / 1ps

module mbd_decode import mbd_pkg::*; (
    input  t_item      i_item,
    input  logic [7:0] i_port,
    output t_result    o_result,
    output logic       o_port_wr
);

    logic [15:0] a;
    logic [2:0]  region;
    logic [1:0]  bank;
    logic [13:0] a14;
    logic [3:0]  io_tgt;
    logic [15:0] io_off;

    assign a = i_item.address;

    // map region for this address under the current port row
    always_comb begin
        region = MAP_RAM;
        if (a[15:13] == 3'b101) begin
            region = map_cell(i_port[2:0], 2'd0);
        end else if (a[15:12] == 4'hD) begin
            region = map_cell(i_port[2:0], 2'd1);
        end else if (a[15:13] == 3'b111) begin
            region = map_cell(i_port[2:0], 2'd2);
        end
    end

    // I/O page split, valid inside D000-DFFF
    always_comb begin
        io_tgt = TGT_IO2;
        io_off = {8'd0, a[7:0]};
        case (a[11:10])
            2'b00: begin
                io_tgt = TGT_VIDEO;
                io_off = {10'd0, a[5:0]};
            end
            2'b01: begin
                io_tgt = TGT_SOUND;
                io_off = {6'd0, a[9:0]};
            end
            2'b10: begin
                io_tgt = TGT_COLOUR;
                io_off = {6'd0, a[9:0]};
            end
            default: begin
                case (a[9:8])
                    2'b00: begin
                        io_tgt = TGT_CIA1;
                        io_off = {12'd0, a[3:0]};
                    end
                    2'b01: begin
                        io_tgt = TGT_CIA2;
                        io_off = {12'd0, a[3:0]};
                    end
                    2'b10: begin
                        io_tgt = TGT_IO1;
                        io_off = {8'd0, a[7:0]};
                    end
                    default: begin
                        io_tgt = TGT_IO2;
                        io_off = {8'd0, a[7:0]};
                    end
                endcase
            end
        endcase
    end

    // video side sees the inverted bank bits
    assign bank = ~i_item.video_bank_bits;
    assign a14  = a[13:0];

    // per-kind decode
    always_comb begin
        o_result.target     = TGT_RAM;
        o_result.offset     = a;
        o_result.port_value = 8'd0;
        o_port_wr           = 1'b0;
        unique case (i_item.kind)
            KIND_VIDEO_READ: begin
                if (!bank[0] && a14[13:12] == 2'b01) begin
                    o_result.target = TGT_CHAR;
                    o_result.offset = {4'd0, a[11:0]};
                end else begin
                    o_result.target = TGT_RAM;
                    o_result.offset = {bank, a14};
                end
            end
            KIND_CPU_WRITE: begin
                if (region == MAP_IO) begin
                    o_result.target = io_tgt;
                    o_result.offset = io_off;
                end
                o_port_wr = (a == ADDR_PORT);
            end
            default: begin
                if (a == ADDR_PORT) begin
                    o_result.target     = TGT_PORT;
                    o_result.offset     = ADDR_PORT;
                    o_result.port_value = i_port | PORT_FORCE;
                end else begin
                    unique case (region)
                        MAP_BASIC: begin
                            o_result.target = TGT_BASIC;
                            o_result.offset = a - BASIC_BASE;
                        end
                        MAP_KERNAL: begin
                            o_result.target = TGT_KERNAL;
                            o_result.offset = a - KERNAL_BASE;
                        end
                        MAP_CHAR: begin
                            o_result.target = TGT_CHAR;
                            o_result.offset = a - CHAR_BASE;
                        end
                        MAP_IO: begin
                            o_result.target = io_tgt;
                            o_result.offset = io_off;
                        end
                        default: begin
                            o_result.target = TGT_RAM;
                            o_result.offset = a;
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

// File: hdl/memory_bank_decoder.sv
`timescale 1ns / 1ps

// Bank-switching address decoder.
// Input channel: i_in_valid / o_in_stall carry one access per beat (kind,
// address, write data, video bank bits). Output channel: o_out_valid /
// i_out_stall carry the decoded target device, offset and port value.
// Each beat is captured in an input register, decoded by one pass of
// combinational logic and held in a result register, so a result reaches
// the output from the result register once the input register passes it on. Throughput is one
// beat per cycle while the receiver does not stall; the processor-port register is updated as a write to
// address 1 leaves the input register, so the next beat already sees it.
// Reset (synchronous, i_rst_n low) empties both registers and loads the
// port register with 0x37.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more beat, after which o_in_stall rises until
// the output moves again.
module memory_bank_decoder import mbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [1:0]  i_video_bank_bits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_target,
    output logic [15:0] o_offset,
    output logic [7:0]  o_port_value
);

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    logic [7:0] r_port;

    t_result n_out;
    logic    dec_port_wr;
    logic    out_load;
    logic    in_load;

    // handshake: result register frees when empty or taken
    assign out_load   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_load;
    assign in_load    = i_in_valid && !o_in_stall;

    mbd_decode u_decode (
        .i_item    (r_in),
        .i_port    (r_port),
        .o_result  (n_out),
        .o_port_wr (dec_port_wr)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (in_load) begin
            r_in.kind            <= i_kind;
            r_in.address         <= i_address;
            r_in.write_data      <= i_write_data;
            r_in.video_bank_bits <= i_video_bank_bits;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
        if (out_load && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // processor port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port <= PORT_RESET;
        end else if (out_load && r_in_valid && dec_port_wr) begin
            r_port <= r_in.write_data;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_target     = r_out.target;
    assign o_offset     = r_out.offset;
    assign o_port_value = r_out.port_value;

endmodule

// File: sim/memory_bank_decoder_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the bank decoder, keeps its own copy of the
// processor port and predicts the decoded target for every accepted beat.
module memory_bank_decoder_checker import mbd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_write_data,
    input  logic [1:0]  i_video_bank_bits,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [3:0]  i_target,
    input  logic [15:0] i_offset,
    input  logic [7:0]  i_port_value,
    output int          o_fail_count,
    output int          o_pending
);

    t_result    decoded_q[$];
    logic [7:0] port_copy;
    int         fail_count = 0;
    int         result_no  = 0;
    t_item      beat;
    t_result    want;

    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        fail_count++;
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 result_no, what, got_v, want_v);
    endtask

    // what the port selects for a given address: A000, D000 and E000 windows
    function automatic logic [2:0] region_at(input logic [2:0] row, input logic [15:0] addr);
        if (addr >= BASIC_BASE && addr < 16'hC000)
            return (row[1:0] == 2'b11) ? MAP_BASIC : MAP_RAM;
        if (addr >= CHAR_BASE && addr < KERNAL_BASE) begin
            if (row[1:0] == 2'b00)
                return MAP_RAM;
            return row[2] ? MAP_IO : MAP_CHAR;
        end
        if (addr >= KERNAL_BASE)
            return row[1] ? MAP_KERNAL : MAP_RAM;
        return MAP_RAM;
    endfunction

    // split of the D000-DFFF I/O window into devices
    function automatic t_result io_device(input logic [15:0] addr);
        t_result r;
        r = '0;
        if (addr < 16'hD400) begin
            r.target = TGT_VIDEO;
            r.offset = addr & 16'h003F;
        end else if (addr < 16'hD800) begin
            r.target = TGT_SOUND;
            r.offset = addr & 16'h03FF;
        end else if (addr < 16'hDC00) begin
            r.target = TGT_COLOUR;
            r.offset = addr & 16'h03FF;
        end else if (addr < 16'hDD00) begin
            r.target = TGT_CIA1;
            r.offset = addr & 16'h000F;
        end else if (addr < 16'hDE00) begin
            r.target = TGT_CIA2;
            r.offset = addr & 16'h000F;
        end else if (addr < 16'hDF00) begin
            r.target = TGT_IO1;
            r.offset = addr & 16'h00FF;
        end else begin
            r.target = TGT_IO2;
            r.offset = addr & 16'h00FF;
        end
        return r;
    endfunction

    function automatic t_result decode_access(input t_item b, input logic [7:0] port);
        t_result     r;
        logic [1:0]  bank;
        logic [13:0] a14;
        logic [2:0]  region;
        r      = '0;
        region = region_at(port[2:0], b.address);
        case (b.kind)
            KIND_VIDEO_READ: begin
                // bank bits come in inverted; even banks see char ROM at 1000-1FFF
                bank = ~b.video_bank_bits;
                a14  = b.address[13:0];
                if (!bank[0] && a14[13:12] == 2'b01) begin
                    r.target = TGT_CHAR;
                    r.offset = {4'h0, b.address[11:0]};
                end else begin
                    r.target = TGT_RAM;
                    r.offset = {bank, a14};
                end
            end
            KIND_CPU_WRITE: begin
                // writes under a ROM fall through to RAM
                if (region == MAP_IO) begin
                    r = io_device(b.address);
                end else begin
                    r.target = TGT_RAM;
                    r.offset = b.address;
                end
            end
            default: begin
                // cpu read, and the unused kind decoded the same way
                if (b.address == ADDR_PORT) begin
                    r.target     = TGT_PORT;
                    r.offset     = 16'h0001;
                    r.port_value = port | PORT_FORCE;
                end else begin
                    case (region)
                        MAP_BASIC: begin
                            r.target = TGT_BASIC;
                            r.offset = b.address - BASIC_BASE;
                        end
                        MAP_KERNAL: begin
                            r.target = TGT_KERNAL;
                            r.offset = b.address - KERNAL_BASE;
                        end
                        MAP_CHAR: begin
                            r.target = TGT_CHAR;
                            r.offset = b.address - CHAR_BASE;
                        end
                        MAP_IO: r = io_device(b.address);
                        default: begin
                            r.target = TGT_RAM;
                            r.offset = b.address;
                        end
                    endcase
                end
            end
        endcase
        return r;
    endfunction

    // compare the outgoing beat first, then predict the incoming one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            decoded_q.delete();
            port_copy = PORT_RESET;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected result, target", i_target, 0);
                end else begin
                    want = decoded_q.pop_front();
                    if (i_target !== want.target)
                        report_mismatch("target", i_target, want.target);
                    if (i_offset !== want.offset)
                        report_mismatch("offset", i_offset, want.offset);
                    if (i_port_value !== want.port_value)
                        report_mismatch("port value", i_port_value, want.port_value);
                end
                result_no++;
            end
            if (i_in_valid && !i_in_stall) begin
                beat.kind            = i_kind;
                beat.address         = i_address;
                beat.write_data      = i_write_data;
                beat.video_bank_bits = i_video_bank_bits;
                decoded_q.push_back(decode_access(beat, port_copy));
                if (beat.kind == KIND_CPU_WRITE && beat.address == ADDR_PORT)
                    port_copy = beat.write_data;
            end
        end
        o_pending <= decoded_q.size();
    end

endmodule

// File: sim/memory_bank_decoder_tb.sv
`timescale 1ns / 1ps

module memory_bank_decoder_tb;
    import mbd_pkg::*;

    // kind 3 has no name in the package; it decodes as a cpu read
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam int ITEMS_PER_PHASE = 438;
    localparam int STALL_LIMIT     = 1000;

    logic        i_clk             = 1'b0;
    logic        i_rst_n           = 1'b0;
    logic        i_in_valid        = 1'b0;
    logic [1:0]  i_kind            = '0;
    logic [15:0] i_address         = '0;
    logic [7:0]  i_write_data      = '0;
    logic [1:0]  i_video_bank_bits = '0;
    logic        i_out_stall       = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [3:0]  o_target;
    logic [15:0] o_offset;
    logic [7:0]  o_port_value;

    int fail_count;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int quiet_cycles = 0;

    memory_bank_decoder dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .i_video_bank_bits (i_video_bank_bits),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_target          (o_target),
        .o_offset          (o_offset),
        .o_port_value      (o_port_value)
    );

    memory_bank_decoder_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_kind            (i_kind),
        .i_address         (i_address),
        .i_write_data      (i_write_data),
        .i_video_bank_bits (i_video_bank_bits),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_target          (o_target),
        .i_offset          (o_offset),
        .i_port_value      (o_port_value),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // watchdog: too long without any beat moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet_cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one beat, with random idle cycles ahead of it; held until accepted
    task automatic send_access(input logic [1:0] kind, input logic [15:0] addr,
                               input logic [7:0] data, input logic [1:0] vbits);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_kind            <= kind;
        i_address         <= addr;
        i_write_data      <= data;
        i_video_bank_bits <= vbits;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
    endtask

    function automatic logic [15:0] boundary_address();
        case ($urandom_range(0, 15))
            0:  return 16'h0000;
            1:  return 16'h0002;
            2:  return 16'h9FFF;
            3:  return 16'hA000;
            4:  return 16'hBFFF;
            5:  return 16'hC000;
            6:  return 16'hCFFF;
            7:  return 16'hD3FF;
            8:  return 16'hD400;
            9:  return 16'hD7FF;
            10: return 16'hDBFF;
            11: return 16'hDCFF;
            12: return 16'hDDFF;
            13: return 16'hDEFF;
            14: return 16'hDF00;
            default: return 16'hFFFF;
        endcase
    endfunction

    // addresses weighted toward the port and the switched windows
    function automatic logic [15:0] pick_address();
        case ($urandom_range(0, 9))
            0:       return ADDR_PORT;
            1:       return 16'($urandom_range(16'hA000, 16'hBFFF));
            2, 3:    return 16'($urandom_range(16'hD000, 16'hDFFF));
            4:       return 16'($urandom_range(16'hE000, 16'hFFFF));
            5:       return boundary_address();
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic random_access();
        logic [1:0] kind;
        int         pick;
        pick = $urandom_range(0, 15);
        if (pick < 6)
            kind = KIND_CPU_READ;
        else if (pick < 11)
            kind = KIND_CPU_WRITE;
        else if (pick < 15)
            kind = KIND_VIDEO_READ;
        else
            kind = KIND_SPARE;
        send_access(kind, pick_address(), 8'($urandom_range(0, 255)),
                    2'($urandom_range(0, 3)));
    endtask

    initial begin
        int phase;
        int n;
        int idle_set [4];
        int stall_set [4];
        idle_set  = '{0, 48, 0, 34};
        stall_set = '{0, 0, 48, 34};

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: map row 7 out of reset, then the port moved around
        send_access(KIND_CPU_READ, ADDR_PORT, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hA000, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hBFFF, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hD000, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hD400, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hD800, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hDC0F, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hDDFF, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hDE80, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hDFFF, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hFFFF, 8'h00, 2'b00);
        // writes under ROM land in RAM; the D020 write goes to the video device
        send_access(KIND_CPU_WRITE, 16'hA000, 8'hFF, 2'b11);
        send_access(KIND_CPU_WRITE, 16'hD020, 8'h55, 2'b00);
        send_access(KIND_CPU_WRITE, 16'hE000, 8'hAA, 2'b00);
        // video reads in all four banks
        send_access(KIND_VIDEO_READ, 16'h1000, 8'h00, 2'b11);
        send_access(KIND_VIDEO_READ, 16'hDFFF, 8'h00, 2'b01);
        send_access(KIND_VIDEO_READ, 16'hFFFF, 8'hFF, 2'b00);
        send_access(KIND_VIDEO_READ, 16'h1000, 8'h00, 2'b10);
        send_access(KIND_SPARE, 16'hE000, 8'h00, 2'b00);
        // port to row 0, read back, then row 3 with char ROM
        send_access(KIND_CPU_WRITE, ADDR_PORT, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'hA000, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, ADDR_PORT, 8'h00, 2'b00);
        send_access(KIND_CPU_WRITE, ADDR_PORT, 8'hFB, 2'b00);
        send_access(KIND_CPU_READ, 16'hD000, 8'h00, 2'b00);
        send_access(KIND_CPU_READ, 16'h0000, 8'h00, 2'b00);

        // random part, one phase per idle and stall mix; drain fully between phases
        for (phase = 0; phase < 4; phase++) begin
            i_in_valid <= 1'b0;
            // let the count catch up with the last accepted beat
            @(posedge i_clk);
            while (pending != 0)
                @(posedge i_clk);
            @(posedge i_clk);
            idle_pct  = idle_set[phase];
            stall_pct <= stall_set[phase];
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                random_access();
        end

        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
